FILE: src/ulbp_pkg.sv
// Package for the uniform LBP pixel labeler: field widths and the code-to-label table.
// No dependencies; imported by the labeler top level.
package ulbp_pkg;

    localparam int PIXEL_W  = 8;
    localparam int LABEL_W  = 6;
    localparam int CFG_W    = 11;
    localparam int NUM_CODES = 256;
    localparam int MAX_TRANSITIONS = 2;

    typedef logic [LABEL_W-1:0] label_t;
    typedef label_t label_table_t [NUM_CODES];

    // count circular 0/1 transitions of an 8-bit code
    function automatic int code_transitions(input logic [7:0] code);
        logic [7:0] rot;
        logic [7:0] diff;
        int         n;
        rot  = {code[6:0], code[7]};
        diff = code ^ rot;
        n    = 0;
        for (int i = 0; i < 8; i++)
        begin
            n += int'(diff[i]);
        end
        return n;
    endfunction

    // uniform codes get labels 1..58 in ascending code order, the rest 0
    function automatic label_table_t build_label_table();
        label_table_t tbl;
        int           lab;
        lab = 1;
        for (int c = 0; c < NUM_CODES; c++)
        begin
            if (code_transitions(8'(c)) <= MAX_TRANSITIONS)
            begin
                tbl[c] = LABEL_W'(lab);
                lab++;
            end
            else
            begin
                tbl[c] = '0;
            end
        end
        return tbl;
    endfunction

    localparam label_table_t LABEL_TABLE = build_label_table();

endpackage

FILE: src/uniform_lbp_pixel_labeler.sv
// Uniform LBP labeler: two line stores, 3x3 window, 59-label uniform pattern map.
// Depends on ulbp_pkg for widths and the label table.
// A result passes through the line store read register, then the result register (label).
// Throughput: one pixel per cycle; the line store read register and the result register
// form a two-stage pipeline that advances whenever the result register is free.
// Reset: clear counters, window and valid flags; image_width to 640; stores undefined.
module uniform_lbp_pixel_labeler
    import ulbp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,       // image_width
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]          s_axis_tuser,   // [0] frame_start
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [5:0] label, [7:6] zero
    output logic [0:0]          m_axis_tuser    // [0] label_valid
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [WW-1:0] MIN_W = WW'(3);
    localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

    logic [CFG_W-1:0]   width_reg;
    logic [AW-1:0]      col_reg;
    logic [1:0]         row_reg;

    logic               s1_valid_reg;
    logic [AW-1:0]      s1_col_reg;
    logic               s1_lv_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [PIXEL_W-1:0] top_rd_reg;
    logic [PIXEL_W-1:0] mid_rd_reg;

    logic [PIXEL_W-1:0] win_reg [6];

    logic               out_valid_reg;
    label_t             out_label_reg;
    logic               out_lv_reg;

    logic [PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];

    logic [WW-1:0]      width_ext;
    logic [WW-1:0]      eff_w;
    logic               out_free;
    logic               s1_adv;
    logic               in_acc;
    logic               cfg_acc;
    logic [AW-1:0]      col_cur;
    logic [1:0]         row_cur;
    logic               lv_cur;
    logic [WW-1:0]      col_inc;
    logic [AW-1:0]      col_next;
    logic [1:0]         row_next;
    logic [PIXEL_W-1:0] nb [8];
    logic [PIXEL_W-1:0] center;
    logic [7:0]         code;
    label_t             label_next;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;

    assign width_ext = WW'(width_reg);
    always_comb
    begin
        if (width_ext < MIN_W)
        begin
            eff_w = MIN_W;
        end
        else if (width_ext > MAX_W)
        begin
            eff_w = MAX_W;
        end
        else
        begin
            eff_w = width_ext;
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        col_cur  = s_axis_tuser[0] ? '0 : col_reg;
        row_cur  = s_axis_tuser[0] ? 2'd0 : row_reg;
        lv_cur   = (row_cur == 2'd2) && (col_cur >= AW'(2));
        col_inc  = WW'(col_cur) + WW'(1);
        col_next = AW'(col_inc);
        row_next = row_cur;
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            if (row_cur != 2'd2)
            begin
                row_next = row_cur + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CFG_W'(640);
            col_reg   <= '0;
            row_reg   <= 2'd0;
        end
        else if (cfg_acc)
        begin
            width_reg <= cfg_data;
            col_reg   <= '0;
            row_reg   <= 2'd0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_col_reg <= col_cur;
            s1_lv_reg  <= lv_cur;
            s1_px_reg  <= s_axis_tdata[PIXEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            top_rd_reg <= upper_mem[col_cur];
        end
        if (s1_adv)
        begin
            upper_mem[s1_col_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mid_rd_reg <= middle_mem[col_cur];
        end
        if (s1_adv)
        begin
            middle_mem[s1_col_reg] <= s1_px_reg;
        end
    end

    always_comb
    begin
        nb[0]  = win_reg[0];
        nb[1]  = win_reg[1];
        nb[2]  = top_rd_reg;
        nb[3]  = mid_rd_reg;
        nb[4]  = s1_px_reg;
        nb[5]  = win_reg[5];
        nb[6]  = win_reg[4];
        nb[7]  = win_reg[2];
        center = win_reg[3];
        for (int k = 0; k < 8; k++)
        begin
            code[k] = (nb[k] >= center);
        end
        label_next = s1_lv_reg ? LABEL_TABLE[code] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_rd_reg;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_rd_reg;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_label_reg <= label_next;
            out_lv_reg    <= s1_lv_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {2'b00, out_label_reg};
    assign m_axis_tuser[0] = out_lv_reg;

endmodule

FILE: src/ulbp_checker.sv
// Port-level checks for the uniform LBP labeler, bound to its top level.
// Depends only on the top level's ports.
module ulbp_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [0:0] m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("border item carries a nonzero label");

    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 8'd58)
        else $error("label out of range");

endmodule

bind uniform_lbp_pixel_labeler ulbp_checker u_ulbp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
